// ===== rtl/segi_pkg.sv =====
// Shared types, widths and helpers for the segment intersection pipeline.
// No dependencies.
package segi_pkg;

    localparam int CW = 32;   // coordinate width
    localparam int DW = 33;   // coordinate difference width
    localparam int PW = 66;   // product of two differences
    localparam int XW = 67;   // cross product width
    localparam int QW = 41;   // quotient bits, one per divider cell
    localparam int RW = 110;  // remainder / shifted divisor width

    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_POINT   = 2'd1;
    localparam logic [1:0] ST_OVERLAP = 2'd2;

    typedef struct packed {
        logic signed [CW-1:0] a_x1;
        logic signed [CW-1:0] a_y1;
        logic signed [CW-1:0] a_x2;
        logic signed [CW-1:0] a_y2;
        logic signed [CW-1:0] b_x1;
        logic signed [CW-1:0] b_y1;
        logic signed [CW-1:0] b_x2;
        logic signed [CW-1:0] b_y2;
    } seg_in_t;

    typedef struct packed {
        logic [1:0]           status;
        logic signed [CW-1:0] cross_x;
        logic signed [CW-1:0] cross_y;
    } seg_out_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [XW-1:0]        tn;
        logic [XW-1:0]        den;
        logic signed [CW-1:0] ax1;
        logic signed [CW-1:0] ay1;
        logic signed [DW-1:0] dxa;
        logic signed [DW-1:0] dya;
    } front_word_t;

    typedef struct packed {
        logic [1:0]           status;
        logic signed [CW-1:0] ax1;
        logic signed [CW-1:0] ay1;
        logic                 neg_x;
        logic                 neg_y;
    } div_side_t;

    typedef struct packed {
        logic [RW-1:0] rem_x;
        logic [RW-1:0] rem_y;
        logic [RW-1:0] dvs;
        logic [QW-1:0] q_x;
        logic [QW-1:0] q_y;
        div_side_t     side;
    } div_word_t;

    function automatic logic in_box(
        input logic signed [CW-1:0] px, input logic signed [CW-1:0] py,
        input logic signed [CW-1:0] x1, input logic signed [CW-1:0] y1,
        input logic signed [CW-1:0] x2, input logic signed [CW-1:0] y2);
        logic signed [CW-1:0] lx, hx, ly, hy;
        lx = (x1 < x2) ? x1 : x2;
        hx = (x1 < x2) ? x2 : x1;
        ly = (y1 < y2) ? y1 : y2;
        hy = (y1 < y2) ? y2 : y1;
        return (px >= lx) && (px <= hx) && (py >= ly) && (py <= hy);
    endfunction

    function automatic logic signed [CW-1:0] sat32(input logic signed [CW+10:0] v);
        logic signed [CW+10:0] hi, lo;
        hi = (CW+11)'(33'sd2147483647);
        lo = -(CW+11)'(33'sd2147483648);
        if (v > hi) return hi[CW-1:0];
        if (v < lo) return lo[CW-1:0];
        return v[CW-1:0];
    endfunction

endpackage

// ===== rtl/segi_front.sv =====
// Front pipeline: differences, box tests, cross products and the decision.
// Depends on segi_pkg.
module segi_front import segi_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  seg_in_t     in_data,
    output logic        out_valid,
    output front_word_t out_word
);

    seg_in_t r1_reg;
    logic    v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // stage 1 -> 2: differences and box tests
    logic signed [DW-1:0] dxa_c, dya_c, dxb_c, dyb_c, ex_c, ey_c;
    logic box_c;
    assign dxa_c = DW'(r1_reg.a_x2) - DW'(r1_reg.a_x1);
    assign dya_c = DW'(r1_reg.a_y2) - DW'(r1_reg.a_y1);
    assign dxb_c = DW'(r1_reg.b_x2) - DW'(r1_reg.b_x1);
    assign dyb_c = DW'(r1_reg.b_y2) - DW'(r1_reg.b_y1);
    assign ex_c  = DW'(r1_reg.b_x1) - DW'(r1_reg.a_x1);
    assign ey_c  = DW'(r1_reg.b_y1) - DW'(r1_reg.a_y1);
    assign box_c =
        in_box(r1_reg.b_x1, r1_reg.b_y1, r1_reg.a_x1, r1_reg.a_y1, r1_reg.a_x2, r1_reg.a_y2) ||
        in_box(r1_reg.b_x2, r1_reg.b_y2, r1_reg.a_x1, r1_reg.a_y1, r1_reg.a_x2, r1_reg.a_y2) ||
        in_box(r1_reg.a_x1, r1_reg.a_y1, r1_reg.b_x1, r1_reg.b_y1, r1_reg.b_x2, r1_reg.b_y2) ||
        in_box(r1_reg.a_x2, r1_reg.a_y2, r1_reg.b_x1, r1_reg.b_y1, r1_reg.b_x2, r1_reg.b_y2);

    logic signed [DW-1:0] dxa2_reg, dya2_reg, dxb2_reg, dyb2_reg, ex2_reg, ey2_reg;
    logic                 box2_reg;
    logic signed [CW-1:0] ax2_reg, ay2_reg;

    // stage 2 -> 3: six products
    logic signed [PW-1:0] p0_c, p1_c, p2_c, p3_c, p4_c, p5_c;
    assign p0_c = PW'(dxa2_reg) * PW'(dyb2_reg);
    assign p1_c = PW'(dya2_reg) * PW'(dxb2_reg);
    assign p2_c = PW'(ex2_reg) * PW'(dyb2_reg);
    assign p3_c = PW'(ey2_reg) * PW'(dxb2_reg);
    assign p4_c = PW'(ex2_reg) * PW'(dya2_reg);
    assign p5_c = PW'(ey2_reg) * PW'(dxa2_reg);

    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic                 box3_reg, apt3_reg, bpt3_reg;
    logic signed [CW-1:0] ax3_reg, ay3_reg;
    logic signed [DW-1:0] dxa3_reg, dya3_reg;

    // stage 3 -> 4: cross products
    logic signed [XW-1:0] den4_reg, tn4_reg, un4_reg;
    logic                 box4_reg, apt4_reg, bpt4_reg;
    logic signed [CW-1:0] ax4_reg, ay4_reg;
    logic signed [DW-1:0] dxa4_reg, dya4_reg;

    // stage 4 -> 5: sign fix and decision
    logic signed [XW-1:0] denp, tnp, unp, dmt, dmu;
    logic                 collinear, hit;
    logic [1:0]           status_c;
    front_word_t          word_reg;

    always_comb begin
        denp = den4_reg[XW-1] ? -den4_reg : den4_reg;
        tnp  = den4_reg[XW-1] ? -tn4_reg  : tn4_reg;
        unp  = den4_reg[XW-1] ? -un4_reg  : un4_reg;
        dmt  = denp - tnp;
        dmu  = denp - unp;
        hit  = !tnp[XW-1] && !unp[XW-1] && !dmt[XW-1] && !dmu[XW-1];
        if (!apt4_reg)      collinear = (un4_reg == '0);
        else if (!bpt4_reg) collinear = (tn4_reg == '0);
        else                collinear = 1'b1;
        if (den4_reg == '0) status_c = (collinear && box4_reg) ? ST_OVERLAP : ST_NONE;
        else                status_c = hit ? ST_POINT : ST_NONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r1_reg   <= in_data;
            dxa2_reg <= dxa_c;
            dya2_reg <= dya_c;
            dxb2_reg <= dxb_c;
            dyb2_reg <= dyb_c;
            ex2_reg  <= ex_c;
            ey2_reg  <= ey_c;
            box2_reg <= box_c;
            ax2_reg  <= r1_reg.a_x1;
            ay2_reg  <= r1_reg.a_y1;

            p0_reg   <= p0_c;
            p1_reg   <= p1_c;
            p2_reg   <= p2_c;
            p3_reg   <= p3_c;
            p4_reg   <= p4_c;
            p5_reg   <= p5_c;
            box3_reg <= box2_reg;
            apt3_reg <= (dxa2_reg == '0) && (dya2_reg == '0);
            bpt3_reg <= (dxb2_reg == '0) && (dyb2_reg == '0);
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            dxa3_reg <= dxa2_reg;
            dya3_reg <= dya2_reg;

            den4_reg <= XW'(p0_reg) - XW'(p1_reg);
            tn4_reg  <= XW'(p2_reg) - XW'(p3_reg);
            un4_reg  <= XW'(p4_reg) - XW'(p5_reg);
            box4_reg <= box3_reg;
            apt4_reg <= apt3_reg;
            bpt4_reg <= bpt3_reg;
            ax4_reg  <= ax3_reg;
            ay4_reg  <= ay3_reg;
            dxa4_reg <= dxa3_reg;
            dya4_reg <= dya3_reg;

            word_reg.status <= status_c;
            word_reg.tn     <= tnp;
            word_reg.den    <= denp;
            word_reg.ax1    <= ax4_reg;
            word_reg.ay1    <= ay4_reg;
            word_reg.dxa    <= dxa4_reg;
            word_reg.dya    <= dya4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign out_word  = word_reg;

endmodule

// ===== rtl/segi_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit for both lanes.
// Depends on segi_pkg.
module segi_div_cell import segi_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  div_word_t in_word,
    output logic      out_valid,
    output div_word_t out_word
);

    logic      valid_reg;
    div_word_t word_reg, word_next;
    logic      ge_x, ge_y;

    always_comb begin
        ge_x = in_word.rem_x >= in_word.dvs;
        ge_y = in_word.rem_y >= in_word.dvs;
        word_next       = in_word;
        word_next.rem_x = ge_x ? in_word.rem_x - in_word.dvs : in_word.rem_x;
        word_next.rem_y = ge_y ? in_word.rem_y - in_word.dvs : in_word.rem_y;
        word_next.q_x   = {in_word.q_x[QW-2:0], ge_x};
        word_next.q_y   = {in_word.q_y[QW-2:0], ge_y};
        word_next.dvs   = in_word.dvs >> 1;  // advance to the next lower bit
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else if (en)  valid_reg <= in_valid;
    end

    always_ff @(posedge aclk) begin
        if (en) word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== rtl/segment_intersection.sv =====
// Top level: front pipeline, interpolation multiply, divider cell chain, output.
// Depends on segi_pkg, segi_front, segi_div_cell.
//
//  channel | direction | word      | accepted when
//  s_      | in        | seg_in_t  | s_valid && s_ready
//  m_      | out       | seg_out_t | m_valid && m_ready
//
// One word per cycle while the output is not stalled; the path runs through 5 front
// stages, 2 interpolation stages, 41 divider cells and the output register.
// The 41-cell chain resolves one quotient bit per cell for x and y together.
// aresetn is synchronous, active low, and clears only the valid bits.
// The whole pipeline holds when the output word is stalled (s_ready low).
module segment_intersection import segi_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  seg_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output seg_out_t m_data
);

    logic        en;
    logic        fv;
    front_word_t fw;

    // advance everything whenever the output slot is free or being drained
    assign en      = m_ready || !m_valid;
    assign s_ready = en;

    segi_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (fv),
        .out_word  (fw)
    );

    // interpolation: |d| * tn split into two partial products per lane
    logic [DW-1:0] mx, my;
    assign mx = fw.dxa[DW-1] ? DW'(-fw.dxa) : DW'(fw.dxa);
    assign my = fw.dya[DW-1] ? DW'(-fw.dya) : DW'(fw.dya);

    logic            ml_valid_reg;
    logic [66:0]     pxl_reg, pyl_reg;
    logic [65:0]     pxh_reg, pyh_reg;
    logic [XW-1:0]   ml_den_reg;
    div_side_t       ml_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) ml_valid_reg <= 1'b0;
        else if (en)  ml_valid_reg <= fv;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pxl_reg            <= 67'(mx) * 67'(fw.tn[33:0]);
            pyl_reg            <= 67'(my) * 67'(fw.tn[33:0]);
            pxh_reg            <= 66'(mx) * 66'(fw.tn[XW-1:34]);
            pyh_reg            <= 66'(my) * 66'(fw.tn[XW-1:34]);
            ml_den_reg         <= fw.den;
            ml_side_reg.status <= fw.status;
            ml_side_reg.ax1    <= fw.ax1;
            ml_side_reg.ay1    <= fw.ay1;
            ml_side_reg.neg_x  <= fw.dxa[DW-1];
            ml_side_reg.neg_y  <= fw.dya[DW-1];
        end
    end

    // numerator 2*d*tn + den as sign and magnitude; for a negative d form
    // den - 2p and 2p - den side by side and keep the non-negative one
    logic [99:0]  px, py;
    logic [103:0] x_sum, x_dmp, x_pmd, y_sum, y_dmp, y_pmd;
    logic [103:0] ax_mag, ay_mag;
    logic         x_neg, y_neg;
    div_word_t    head_word;

    always_comb begin
        px = 100'(pxl_reg) + {pxh_reg[65:0], 34'd0};
        py = 100'(pyl_reg) + {pyh_reg[65:0], 34'd0};
        x_sum = {3'd0, px, 1'b0} + 104'(ml_den_reg);
        x_dmp = 104'(ml_den_reg) - {3'd0, px, 1'b0};
        x_pmd = {3'd0, px, 1'b0} - 104'(ml_den_reg);
        y_sum = {3'd0, py, 1'b0} + 104'(ml_den_reg);
        y_dmp = 104'(ml_den_reg) - {3'd0, py, 1'b0};
        y_pmd = {3'd0, py, 1'b0} - 104'(ml_den_reg);
        x_neg = ml_side_reg.neg_x && x_dmp[103];
        y_neg = ml_side_reg.neg_y && y_dmp[103];
        ax_mag = !ml_side_reg.neg_x ? x_sum : (x_dmp[103] ? x_pmd : x_dmp);
        ay_mag = !ml_side_reg.neg_y ? y_sum : (y_dmp[103] ? y_pmd : y_dmp);
        head_word.rem_x      = RW'(ax_mag);
        head_word.rem_y      = RW'(ay_mag);
        head_word.dvs        = RW'({ml_den_reg, 1'b0}) << (QW - 1);
        head_word.q_x        = '0;
        head_word.q_y        = '0;
        head_word.side       = ml_side_reg;
        head_word.side.neg_x = x_neg;
        head_word.side.neg_y = y_neg;
    end

    logic      hd_valid_reg;
    div_word_t hd_word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) hd_valid_reg <= 1'b0;
        else if (en)  hd_valid_reg <= ml_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) hd_word_reg <= head_word;
    end

    // divider chain: cell i resolves quotient bit QW-1-i
    div_word_t chain_w [0:QW];
    logic      chain_v [0:QW];

    assign chain_w[0] = hd_word_reg;
    assign chain_v[0] = hd_valid_reg;

    for (genvar i = 0; i < QW; i++) begin : g_cell
        segi_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (chain_v[i]),
            .in_word   (chain_w[i]),
            .out_valid (chain_v[i+1]),
            .out_word  (chain_w[i+1])
        );
    end

    // floor quotient, add start point, saturate, drop coords unless a point
    div_word_t           tail;
    logic signed [41:0]  qx, qy;
    logic signed [42:0]  sx, sy;
    seg_out_t            out_next, out_reg;
    logic                out_valid_reg;

    always_comb begin
        tail = chain_w[QW];
        qx = $signed({1'b0, tail.q_x});
        qy = $signed({1'b0, tail.q_y});
        if (tail.side.neg_x) qx = -qx - ((tail.rem_x != '0) ? 42'sd1 : 42'sd0);
        if (tail.side.neg_y) qy = -qy - ((tail.rem_y != '0) ? 42'sd1 : 42'sd0);
        sx = 43'(tail.side.ax1) + 43'(qx);
        sy = 43'(tail.side.ay1) + 43'(qy);
        out_next.status = tail.side.status;
        if (tail.side.status == ST_POINT) begin
            out_next.cross_x = sat32(sx);
            out_next.cross_y = sat32(sy);
        end else begin
            out_next.cross_x = '0;
            out_next.cross_y = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) out_valid_reg <= 1'b0;
        else if (en)  out_valid_reg <= chain_v[QW];
    end

    always_ff @(posedge aclk) begin
        if (en) out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == ST_NONE || m_data.status == ST_POINT ||
                     m_data.status == ST_OVERLAP))
        else $error("undefined status code");

    a_zero_coords: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != ST_POINT) |->
            (m_data.cross_x == '0 && m_data.cross_y == '0))
        else $error("coordinates set without a crossing point");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while output word is stalled");

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for segment_intersection: random and directed segment pairs,
// exact wide-integer prediction of status and crossing point.
// Depends on segi_pkg and the segment_intersection RTL.
`timescale 1ns / 100ps

module tb_top;
    import segi_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int LATENCY     = 49;
    localparam int CYCLE_LIMIT = 400000;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    seg_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    seg_out_t m_data;

    segment_intersection i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #1 aclk = ~aclk;

    // Pending segment pairs for the driver, predicted results for the monitor.
    seg_in_t  pending_pairs[$];
    seg_out_t predicted_hits[$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_off_cycles = 0;
    int  mismatches = 0;
    int  cycle_count = 0;
    bit  drive_enable = 1'b0;
    logic s_ready_seen = 1'b0;

    // Round base + d*tn/den (den > 0) to nearest, ties toward +inf, then saturate.
    function automatic logic signed [CW-1:0] round_lerp(
        input logic signed [CW-1:0] base, input logic signed [DW-1:0] d,
        input logic signed [127:0] tn, input logic signed [127:0] den);
        logic signed [127:0] num, q, two_den;
        logic signed [127:0] v;
        num = 128'(d) * tn;
        two_den = den <<< 1;
        num = (num <<< 1) + den;
        q = num / two_den;
        if ((num % two_den != 0) && num < 0) q = q - 1;
        v = 128'(base) + q;
        if (v > 128'sd2147483647) v = 128'sd2147483647;
        if (v < -128'sd2147483648) v = -128'sd2147483648;
        return v[CW-1:0];
    endfunction

    function automatic bit pt_in_box(
        input logic signed [127:0] px, py, x1, y1, x2, y2);
        logic signed [127:0] lx, hx, ly, hy;
        lx = (x1 < x2) ? x1 : x2;
        hx = (x1 < x2) ? x2 : x1;
        ly = (y1 < y2) ? y1 : y2;
        hy = (y1 < y2) ? y2 : y1;
        return px >= lx && px <= hx && py >= ly && py <= hy;
    endfunction

    function automatic seg_out_t predict_crossing(input seg_in_t p);
        logic signed [127:0] dxa, dya, dxb, dyb, ex, ey, den, tn, un;
        logic signed [127:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
        seg_out_t r;
        bit collinear;
        ax1 = 128'(p.a_x1); ay1 = 128'(p.a_y1);
        ax2 = 128'(p.a_x2); ay2 = 128'(p.a_y2);
        bx1 = 128'(p.b_x1); by1 = 128'(p.b_y1);
        bx2 = 128'(p.b_x2); by2 = 128'(p.b_y2);
        dxa = ax2 - ax1; dya = ay2 - ay1;
        dxb = bx2 - bx1; dyb = by2 - by1;
        ex = bx1 - ax1;  ey = by1 - ay1;
        den = dxa * dyb - dya * dxb;
        tn  = ex * dyb - ey * dxb;
        un  = ex * dya - ey * dxa;
        r = '0;
        r.status = ST_NONE;
        if (den == 0) begin
            if (dxa != 0 || dya != 0) collinear = (un == 0);
            else if (dxb != 0 || dyb != 0) collinear = (tn == 0);
            else collinear = 1'b1;
            if (collinear && (pt_in_box(bx1, by1, ax1, ay1, ax2, ay2) ||
                              pt_in_box(bx2, by2, ax1, ay1, ax2, ay2) ||
                              pt_in_box(ax1, ay1, bx1, by1, bx2, by2) ||
                              pt_in_box(ax2, ay2, bx1, by1, bx2, by2)))
                r.status = ST_OVERLAP;
        end else begin
            if (den < 0) begin
                den = -den; tn = -tn; un = -un;
            end
            if (tn >= 0 && un >= 0 && tn <= den && un <= den) begin
                r.status  = ST_POINT;
                r.cross_x = round_lerp(p.a_x1, DW'(dxa), tn, den);
                r.cross_y = round_lerp(p.a_y1, DW'(dya), tn, den);
            end
        end
        return r;
    endfunction

    task automatic queue_pair(input seg_in_t p);
        pending_pairs.push_back(p);
        predicted_hits.push_back(predict_crossing(p));
    endtask

    function automatic logic [CW-1:0] rand_coord(input int span);
        case ($urandom_range(3))
            0: return $urandom;
            1: return CW'($signed($urandom_range(2 * span)) - span);
            2: return CW'($signed($urandom_range(2 * span)) - span) << FRAC_BITS;
            default: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
        endcase
    endfunction

    // Build a random pair; many are shaped to cross, touch or lie collinear.
    task automatic queue_random_pair();
        seg_in_t p;
        logic signed [31:0] k;
        p = {rand_coord(8), rand_coord(8), rand_coord(8), rand_coord(8),
             rand_coord(8), rand_coord(8), rand_coord(8), rand_coord(8)};
        case ($urandom_range(5))
            0: begin
                // B on the line of A, scaled by small integers
                k = $signed($urandom_range(6)) - 3;
                p.a_x1 = rand_coord(50); p.a_y1 = rand_coord(50);
                p.a_x2 = p.a_x1 + 32'($signed($urandom_range(8)) - 4);
                p.a_y2 = p.a_y1 + 32'($signed($urandom_range(8)) - 4);
                p.b_x1 = p.a_x1 + k * (p.a_x2 - p.a_x1);
                p.b_y1 = p.a_y1 + k * (p.a_y2 - p.a_y1);
                p.b_x2 = p.b_x1 + 32'($signed($urandom_range(3))) * (p.a_x2 - p.a_x1);
                p.b_y2 = p.b_y1 + 32'($signed($urandom_range(3))) * (p.a_y2 - p.a_y1);
            end
            1: begin
                // B starts on an end point of A
                p.b_x1 = p.a_x2; p.b_y1 = p.a_y2;
            end
            2: begin
                // degenerate point segments
                p.b_x2 = p.b_x1; p.b_y2 = p.b_y1;
                if ($urandom_range(1)) begin
                    p.a_x2 = p.a_x1; p.a_y2 = p.a_y1;
                end
            end
            3: begin
                // crossing X pattern around a common center
                p.a_x1 = -p.a_x2; p.a_y1 = -p.a_y2;
                p.b_x1 = -p.b_x2; p.b_y1 = -p.b_y2;
            end
            default: ;
        endcase
        queue_pair(p);
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() != 0 || predicted_hits.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    // Record the input handshake at the rising edge for the driver.
    always @(posedge aclk) s_ready_seen <= s_valid && s_ready;

    // Driver: change inputs on the falling edge, hold the word until taken.
    always @(negedge aclk) begin
        if (s_valid && s_ready_seen) begin
            void'(pending_pairs.pop_front());
        end
        if (drive_enable && pending_pairs.size() != 0 &&
            (s_valid && !s_ready_seen || $urandom_range(99) >= send_idle_pct)) begin
            if (!(s_valid && !s_ready_seen)) s_data <= pending_pairs[0];
            s_valid <= 1'b1;
        end else if (!(s_valid && !s_ready_seen)) begin
            s_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, or a long hold-off counted down here.
    always @(negedge aclk) begin
        if (hold_off_cycles > 0) begin
            m_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: compare each output word against the oldest prediction.
    always @(posedge aclk) begin
        seg_out_t want;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_hits.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected word %p", m_data);
            end else begin
                want = predicted_hits.pop_front();
                if (want.status != m_data.status || want.cross_x != m_data.cross_x ||
                    want.cross_y != m_data.cross_y) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: exp st=%0d x=%h y=%h got st=%0d x=%h y=%h",
                                 want.status, want.cross_x, want.cross_y,
                                 m_data.status, m_data.cross_x, m_data.cross_y);
                end
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        drive_enable = 1'b1;

        // Directed: crossings, touches, parallels, collinear, points, extremes.
        queue_pair('{0, 0, 32'h20000, 32'h20000, 0, 32'h20000, 32'h20000, 0});
        queue_pair('{0, 0, 3, 1, 0, 1, 1, 0});
        queue_pair('{0, 0, 32'h10000, 0, 32'h10000, 0, 32'h20000, 32'h10000});
        queue_pair('{0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 32'h10000});
        queue_pair('{0, 0, 32'h20000, 0, 32'h10000, 0, 32'h30000, 0});
        queue_pair('{0, 0, 32'h10000, 0, 32'h20000, 0, 32'h30000, 0});
        queue_pair('{0, 0, 32'h10000, 0, 32'h10000, 0, 32'h20000, 0});
        queue_pair('{5, 5, 5, 5, 5, 5, 5, 5});
        queue_pair('{5, 5, 5, 5, 6, 6, 6, 6});
        queue_pair('{1, 1, 1, 1, 0, 0, 2, 2});
        queue_pair('{0, 0, 2, 2, 1, 1, 1, 1});
        queue_pair('{3, 3, 3, 3, 0, 0, 2, 2});
        queue_pair('{0, 0, 0, 32'h40000, -32'h10000, 32'h10000, 32'h10000, 32'h10000});
        queue_pair('{32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                     32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000});
        queue_pair('{32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                     32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff});
        queue_pair('{32'h7fffffff, 0, 32'h80000000, 1, 0, 32'h80000000, 1, 32'h7fffffff});
        queue_pair('{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                     32'h0, 32'h0, 32'h0, 32'h0});
        queue_pair('{0, 0, 7, 3, 7, 0, 0, 3});
        wait_drained();

        // Random phases: free flow, sender idle, receiver stall, both, long receiver hold-off.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                3: begin send_idle_pct = 30; recv_stall_pct = 30; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            // Long receiver hold-off so the pipeline fills and stalls input.
            if (phase == 4) hold_off_cycles = 300;
            repeat (250) queue_random_pair();
            wait_drained();
        end
        drive_enable = 1'b0;

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/segi_pkg.sv
rtl/segi_front.sv
rtl/segi_div_cell.sv
rtl/segment_intersection.sv
tb/sv/tb_top.sv
